FILE: sv/stt_pkg.sv
// Shared types and codes for the software timer table.
`default_nettype none
package stt_pkg;

  localparam int unsigned NumTimersDefault = 16;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_CREATED = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] delay;
    logic        repeat_req;
    logic [31:0] target_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timer_ident;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic        periodic;
    logic [31:0] ident;
    logic [63:0] deadline;
    logic [31:0] period;
  } slot_t;

endpackage
`default_nettype wire

FILE: sv/stt_cell.sv
// One timer slot of the rotating ring.
`default_nettype none
module stt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire stt_pkg::slot_t slot_i,
  output stt_pkg::slot_t     slot_o
);
  import stt_pkg::*;

  logic  valid_q;
  slot_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= slot_i;
    end
  end

  always_comb begin
    slot_o       = data_q;
    slot_o.valid = valid_q;
  end

endmodule
`default_nettype wire

FILE: sv/software_timer_table.sv
// Top level: timer slots held in a ring of cells, scanned at cell 0.
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid_i/in_stall_o | command, delay, repeat_req, target_id
//  out     | output    | out_valid_o/out_stall_i | kind, timer_ident, last
//
// Tick, create and cancel rotate the ring one slot per cycle past the head cell, with
// out stall freezing the rotation, then a closing state emits the final word (none
// for cancel or for a tick with no expiry). Unused command 3 starts no scan.
// Reset empties every slot, zeroes the tick count and sets the next id to 1.
`default_nettype none
module software_timer_table #(
  parameter int unsigned NUM_TIMERS = stt_pkg::NumTimersDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire stt_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output stt_pkg::out_word_t      out_word_o
);
  import stt_pkg::*;

  localparam int unsigned CntW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0] tick_q, tick_d;
  logic [31:0] next_id_q, next_id_d;
  logic [31:0] res_id_q, res_id_d;
  logic done_q, done_d;
  logic pend_valid_q, pend_valid_d;
  logic [31:0] pend_id_q, pend_id_d;
  in_word_t cmd_q;
  logic out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  slot_t ring [NUM_TIMERS];
  slot_t head_new;
  logic shift;
  logic adv;
  logic accept;
  logic expire;

  assign accept = in_valid_i && !in_stall_o;
  assign adv    = !out_valid_q || !out_stall_i;
  assign shift  = (state_q == ST_SCAN) && adv;
  assign expire = ring[0].valid && (tick_q >= ring[0].deadline);

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    slot_t nb;
    if (k == NUM_TIMERS - 1) begin : g_tail
      assign nb = head_new;
    end else begin : g_mid
      assign nb = ring[k+1];
    end
    stt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (nb),
      .slot_o (ring[k])
    );
  end

  always_comb begin
    head_new     = ring[0];
    state_d      = state_q;
    cnt_d        = cnt_q;
    tick_d       = tick_q;
    next_id_d    = next_id_q;
    res_id_d     = res_id_q;
    done_d       = done_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d        = '0;
          done_d       = 1'b0;
          pend_valid_d = 1'b0;
          if (in_word_i.command == CMD_TICK) begin
            tick_d = tick_q + 64'd1;
          end
          if (in_word_i.command != CMD_NONE) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        case (cmd_q.command)
          CMD_TICK: begin
            if (expire) begin
              if (ring[0].periodic) begin
                head_new.deadline = tick_q + {32'd0, ring[0].period};
              end else begin
                head_new.valid = 1'b0;
              end
            end
          end
          CMD_CREATE: begin
            if (!ring[0].valid && !done_q) begin
              head_new.valid    = 1'b1;
              head_new.periodic = cmd_q.repeat_req;
              head_new.ident    = next_id_q;
              head_new.deadline = tick_q + {32'd0, cmd_q.delay};
              head_new.period   = cmd_q.delay;
            end
          end
          CMD_CANCEL: begin
            if (ring[0].valid && ring[0].ident == cmd_q.target_id && !done_q) begin
              head_new.valid = 1'b0;
            end
          end
          default: ;
        endcase
        if (adv) begin
          case (cmd_q.command)
            CMD_TICK: begin
              if (expire) begin
                if (pend_valid_q) begin
                  out_valid_d = 1'b1;
                  out_d       = '{kind: KIND_EXPIRED, timer_ident: pend_id_q, last: 1'b0};
                end
                pend_valid_d = 1'b1;
                pend_id_d    = ring[0].ident;
              end
            end
            CMD_CREATE: begin
              if (!ring[0].valid && !done_q) begin
                done_d    = 1'b1;
                res_id_d  = next_id_q;
                next_id_d = (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;
              end
            end
            CMD_CANCEL: begin
              if (ring[0].valid && ring[0].ident == cmd_q.target_id) begin
                done_d = 1'b1;
              end
            end
            default: ;
          endcase
          if (cnt_q == CntW'(NUM_TIMERS - 1)) begin
            state_d = ST_FIN;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      ST_FIN: begin
        if (adv) begin
          state_d = ST_IDLE;
          if (cmd_q.command == CMD_TICK && pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_d        = '{kind: KIND_EXPIRED, timer_ident: pend_id_q, last: 1'b1};
            pend_valid_d = 1'b0;
          end else if (cmd_q.command == CMD_CREATE) begin
            out_valid_d = 1'b1;
            if (done_q) begin
              out_d = '{kind: KIND_CREATED, timer_ident: res_id_q, last: 1'b1};
            end else begin
              out_d = '{kind: KIND_FULL, timer_ident: 32'd0, last: 1'b1};
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      tick_q       <= 64'd0;
      next_id_q    <= 32'd1;
      done_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      tick_q       <= tick_d;
      next_id_q    <= next_id_d;
      done_q       <= done_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_id_q  <= res_id_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
    if (accept) begin
      cmd_q <= in_word_i;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_next_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != 32'd0) else $error("next id is zero");

  a_full_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_FULL |-> out_word_o.timer_ident == 32'd0)
    else $error("full word carries an id");

  a_pend_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> cmd_q.command == CMD_TICK && state_q != ST_IDLE)
    else $error("pending expiry outside a tick scan");

  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_word_i.command != CMD_NONE |=> state_q == ST_SCAN && cnt_q == '0)
    else $error("scan did not start");

endmodule
`default_nettype wire
